@@ rtl/lhrl_pkg.sv @@
`timescale 1ns / 1ps

package lhrl_pkg;

  // Request kinds carried on the input tuser field.
  localparam logic [1:0] REQ_CHAR = 2'd0;
  localparam logic [1:0] REQ_EOL  = 2'd1;
  localparam logic [1:0] REQ_LOAD = 2'd2;

  localparam int ADDR_DIGITS    = 6;   // 4 to 6
  localparam int BYTES_PER_LINE = 4;   // 1 to 4

  localparam int ADDR_W     = 24;
  localparam int DATA_W     = 8;
  localparam int COL_W      = 5;
  localparam int MIN_LINE   = 8;
  localparam int DATA_COL0  = 11;
  localparam int DATA_STEP  = 3;
  localparam int TAG_COL    = 6;

  localparam logic [COL_W-1:0]  COL_MAX   = 5'd31;
  localparam logic [COL_W-1:0]  ACCEPT_COL = COL_W'(MIN_LINE - 1);
  localparam logic [COL_W-1:0]  TAG_COLUMN = COL_W'(TAG_COL);
  localparam logic [7:0]        CHAR_NUL  = 8'h00;
  localparam logic [7:0]        CHAR_R    = 8'h72;
  localparam logic [ADDR_W-1:0] ADDR_MAX  = {ADDR_W{1'b1}};

  typedef struct packed {
    logic              write_valid;
    logic [ADDR_W-1:0] write_addr;
    logic [DATA_W-1:0] write_data;
    logic              first_found;
    logic [ADDR_W-1:0] first_addr;
    logic [ADDR_W-1:0] byte_count;
  } lhrl_res_t;

  // Returns {is_hex, value}.
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end
    return r;
  endfunction

endpackage

@@ rtl/lhrl_core.sv @@
`timescale 1ns / 1ps

module lhrl_core #(
  parameter int ADDR_DIGITS    = lhrl_pkg::ADDR_DIGITS,
  parameter int BYTES_PER_LINE = lhrl_pkg::BYTES_PER_LINE
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic [1:0]          req_type,
  input  logic [7:0]          char_code,
  output lhrl_pkg::lhrl_res_t res
);
  import lhrl_pkg::*;

  logic [COL_W-1:0]  column, column_next;
  logic              line_stopped, line_stopped_next;
  logic [ADDR_W-1:0] address_accum, address_accum_next;
  logic              address_ok, address_ok_next;
  logic              line_accepted, line_accepted_next;
  logic [ADDR_W-1:0] next_write_addr, next_write_addr_next;
  logic [3:0]        high_nibble, high_nibble_next;
  logic              high_nibble_ok, high_nibble_ok_next;
  logic [ADDR_W-1:0] first_addr_reg, first_addr_reg_next;
  logic              first_found_reg, first_found_reg_next;
  logic [ADDR_W-1:0] byte_count_reg, byte_count_reg_next;

  logic [4:0] hex;
  logic       is_hex;
  logic       hi_col, lo_col;

  assign hex    = hex_decode(char_code);
  assign is_hex = hex[4];

  // Each data byte sits at two fixed columns; compare against all of them.
  always_comb begin
    hi_col = 1'b0;
    lo_col = 1'b0;
    for (int s = 0; s < BYTES_PER_LINE; s++) begin
      if (column == COL_W'(DATA_COL0 + DATA_STEP * s))     hi_col = 1'b1;
      if (column == COL_W'(DATA_COL0 + DATA_STEP * s + 1)) lo_col = 1'b1;
    end
  end

  always_comb begin
    column_next          = column;
    line_stopped_next    = line_stopped;
    address_accum_next   = address_accum;
    address_ok_next      = address_ok;
    line_accepted_next   = line_accepted;
    next_write_addr_next = next_write_addr;
    high_nibble_next     = high_nibble;
    high_nibble_ok_next  = high_nibble_ok;
    first_addr_reg_next  = first_addr_reg;
    first_found_reg_next = first_found_reg;
    byte_count_reg_next  = byte_count_reg;
    res.write_valid      = 1'b0;
    res.write_addr       = '0;
    res.write_data       = '0;

    case (req_type)
      REQ_EOL, REQ_LOAD: begin
        column_next         = '0;
        line_stopped_next   = 1'b0;
        address_accum_next  = '0;
        address_ok_next     = 1'b1;
        line_accepted_next  = 1'b0;
        high_nibble_next    = '0;
        high_nibble_ok_next = 1'b0;
        if (req_type == REQ_LOAD) begin
          first_addr_reg_next  = '0;
          first_found_reg_next = 1'b0;
          byte_count_reg_next  = '0;
        end
      end
      REQ_CHAR: begin
        if (!line_stopped) begin
          if (char_code == CHAR_NUL) begin
            line_stopped_next = 1'b1;
          end else begin
            if (column < COL_W'(ADDR_DIGITS)) begin
              if (!is_hex) begin
                address_ok_next = 1'b0;
              end else begin
                address_accum_next = {address_accum[ADDR_W-5:0], hex[3:0]};
              end
            end
            if (column == TAG_COLUMN && char_code == CHAR_R) begin
              address_ok_next = 1'b0;
            end
            // Digits before the accept column are all in, so the address is final here.
            if (column == ACCEPT_COL && address_ok) begin
              line_accepted_next   = 1'b1;
              next_write_addr_next = address_accum;
              if (!first_found_reg) begin
                first_found_reg_next = 1'b1;
                first_addr_reg_next  = address_accum;
              end
            end
            if (line_accepted && hi_col) begin
              high_nibble_ok_next = is_hex;
              high_nibble_next    = is_hex ? hex[3:0] : 4'd0;
            end
            if (line_accepted && lo_col) begin
              if (high_nibble_ok && is_hex) begin
                res.write_valid      = 1'b1;
                res.write_addr       = next_write_addr;
                res.write_data       = {high_nibble, hex[3:0]};
                next_write_addr_next = next_write_addr + ADDR_W'(1);
                if (byte_count_reg != ADDR_MAX) begin
                  byte_count_reg_next = byte_count_reg + ADDR_W'(1);
                end
              end
              high_nibble_ok_next = 1'b0;
            end
            if (column != COL_MAX) column_next = column + COL_W'(1);
          end
        end
      end
      default: ;
    endcase

    res.first_found = first_found_reg_next;
    res.first_addr  = first_addr_reg_next;
    res.byte_count  = byte_count_reg_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column          <= '0;
      line_stopped    <= 1'b0;
      address_accum   <= '0;
      address_ok      <= 1'b1;
      line_accepted   <= 1'b0;
      next_write_addr <= '0;
      high_nibble     <= '0;
      high_nibble_ok  <= 1'b0;
      first_addr_reg  <= '0;
      first_found_reg <= 1'b0;
      byte_count_reg  <= '0;
    end else if (step) begin
      column          <= column_next;
      line_stopped    <= line_stopped_next;
      address_accum   <= address_accum_next;
      address_ok      <= address_ok_next;
      line_accepted   <= line_accepted_next;
      next_write_addr <= next_write_addr_next;
      high_nibble     <= high_nibble_next;
      high_nibble_ok  <= high_nibble_ok_next;
      first_addr_reg  <= first_addr_reg_next;
      first_found_reg <= first_found_reg_next;
      byte_count_reg  <= byte_count_reg_next;
    end
  end

endmodule

@@ rtl/listing_hex_record_loader.sv @@
`timescale 1ns / 1ps

// Loads memory bytes from an assembler listing fed one character per request.
// Input channel (s_*): s_tuser gives the request kind (character, end of line,
// start of load), s_tdata the character code. Output channel (m_*): exactly
// one result per request, with a write strobe in m_tuser and the write
// address, data byte, first-line bookmark and saturating byte count in m_tdata.
// A request is registered on acceptance, and its result is registered when
// the request advances into the core, which waits while the output register
// still holds an untaken result. One request per cycle is sustained while
// m_tready stays high; the parser state is a single set of registers
// updated once per request between the two pipeline registers.
// Reset clears the line state, bookmark, byte count and both valid flags; the
// write address counter returns to zero. When the receiver holds m_tready low
// the result register keeps its value, the input register takes at most one
// more request, and then s_tready stays low until the result is taken.
// Start of load clears bookmark and count and also begins a new line.
module listing_hex_record_loader #(
  parameter int ADDR_DIGITS    = lhrl_pkg::ADDR_DIGITS,
  parameter int BYTES_PER_LINE = lhrl_pkg::BYTES_PER_LINE
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] char_code
  input  logic [1:0]  s_tuser,   // [1:0] req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [87:0] m_tdata,   // [23:0] write_addr, [31:24] write_data,
                                 // [32] first_found, [56:33] first_addr,
                                 // [80:57] byte_count, [87:81] zero
  output logic [0:0]  m_tuser    // [0] write_valid
);
  import lhrl_pkg::*;

  logic       in_vld;
  logic [1:0] in_req;
  logic [7:0] in_char;
  logic       advance;
  lhrl_res_t  res;
  lhrl_res_t  out_res;

  assign advance  = in_vld && (!m_tvalid || m_tready);
  assign s_tready = !in_vld || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (s_tready) begin
      in_vld <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_req  <= s_tuser;
      in_char <= s_tdata;
    end
  end

  lhrl_core #(
    .ADDR_DIGITS    (ADDR_DIGITS),
    .BYTES_PER_LINE (BYTES_PER_LINE)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .req_type  (in_req),
    .char_code (in_char),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
    end
  end

  assign m_tuser = out_res.write_valid;
  assign m_tdata = {7'd0, out_res.byte_count, out_res.first_addr, out_res.first_found,
                    out_res.write_data, out_res.write_addr};

  // A write can only come from an accepted line, which sets the bookmark.
  a_write_has_bookmark: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_res.write_valid |-> out_res.first_found)
    else $error("write offered without a bookmarked line");

  a_write_counted: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_res.write_valid |-> out_res.byte_count != '0)
    else $error("write offered with a zero byte count");

  a_bookmark_clear: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !out_res.first_found |-> out_res.first_addr == '0)
    else $error("bookmark address set without a bookmarked line");

  a_stall_backs_up: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> in_vld && m_tvalid && !m_tready)
    else $error("input stalled while the pipeline can move");

endmodule

@@ bench/listing_hex_record_loader_test.sv @@
`timescale 1ns / 1ps

module listing_hex_record_loader_test;
  import lhrl_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 8;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;   // [7:0] char_code
  logic [1:0]  s_tuser = REQ_EOL; // [1:0] req_type
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [87:0] m_tdata;           // [23:0] write_addr, [31:24] write_data,
                                  // [32] first_found, [56:33] first_addr,
                                  // [80:57] byte_count, [87:81] zero
  logic [0:0]  m_tuser;           // [0] write_valid

  listing_hex_record_loader dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  int idle_pct = 0;
  int stall_pct = 0;
  int items_sent = 0;
  int error_count = 0;
  int quiet_cycles = 0;

  // Parser state as the block should hold it.
  logic [COL_W-1:0]  cur_col = '0;
  bit                line_dead = 1'b0;
  logic [ADDR_W-1:0] addr_acc = '0;
  bit                addr_good = 1'b1;
  bit                line_live = 1'b0;
  logic [ADDR_W-1:0] wr_ptr = '0;
  logic [3:0]        hi_nib = '0;
  bit                hi_nib_ok = 1'b0;
  logic [ADDR_W-1:0] bookmark_addr = '0;
  bit                bookmark_set = 1'b0;
  logic [ADDR_W-1:0] bytes_loaded = '0;

  lhrl_res_t parser_results[$];
  lhrl_res_t want;

  function automatic int nibble_of(logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - int'("0");
    if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
    if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
    return -1;
  endfunction

  function automatic logic [7:0] hex_char(int v);
    if (v < 10) return 8'("0" + v);
    return ($urandom_range(1) != 0) ? 8'("a" + v - 10) : 8'("A" + v - 10);
  endfunction

  function automatic logic [7:0] rand_non_hex();
    logic [7:0] c;
    c = 8'($urandom_range(1, 255));
    while (nibble_of(c) >= 0) c = 8'($urandom_range(1, 255));
    return c;
  endfunction

  function automatic void start_line();
    cur_col = '0;
    line_dead = 1'b0;
    addr_acc = '0;
    addr_good = 1'b1;
    line_live = 1'b0;
    hi_nib = '0;
    hi_nib_ok = 1'b0;
  endfunction

  // Advances the parser by one request and queues the result it must produce.
  function automatic void parse_request(logic [1:0] kind, logic [7:0] ch);
    lhrl_res_t r;
    int v;
    int off;
    r = '0;
    v = nibble_of(ch);
    if (kind == REQ_EOL) begin
      start_line();
    end else if (kind == REQ_LOAD) begin
      start_line();
      bookmark_addr = '0;
      bookmark_set = 1'b0;
      bytes_loaded = '0;
    end else if (kind == REQ_CHAR && !line_dead) begin
      if (ch == CHAR_NUL) begin
        line_dead = 1'b1;
      end else begin
        if (cur_col < ADDR_DIGITS) begin
          if (v < 0) addr_good = 1'b0;
          else addr_acc = {addr_acc[ADDR_W-5:0], 4'(v)};
        end
        if (cur_col == TAG_COLUMN && ch == CHAR_R) addr_good = 1'b0;
        if (cur_col == ACCEPT_COL && addr_good) begin
          line_live = 1'b1;
          wr_ptr = addr_acc;
          if (!bookmark_set) begin
            bookmark_set = 1'b1;
            bookmark_addr = addr_acc;
          end
        end
        if (line_live && cur_col >= DATA_COL0) begin
          off = int'(cur_col) - DATA_COL0;
          if (off / DATA_STEP < BYTES_PER_LINE) begin
            if (off % DATA_STEP == 0) begin
              hi_nib_ok = (v >= 0);
              hi_nib = (v >= 0) ? 4'(v) : 4'd0;
            end else if (off % DATA_STEP == 1) begin
              if (hi_nib_ok && v >= 0) begin
                r.write_valid = 1'b1;
                r.write_addr = wr_ptr;
                r.write_data = {hi_nib, 4'(v)};
                wr_ptr = wr_ptr + 1'b1;
                if (bytes_loaded != ADDR_MAX) bytes_loaded = bytes_loaded + 1'b1;
              end
              hi_nib_ok = 1'b0;
            end
          end
        end
        if (cur_col != COL_MAX) cur_col = cur_col + 1'b1;
      end
    end
    r.first_found = bookmark_set;
    r.first_addr = bookmark_addr;
    r.byte_count = bytes_loaded;
    parser_results.push_back(r);
  endfunction

  task automatic flag_mismatch(string what, logic [23:0] got, logic [23:0] exp_val);
    $display("%0t ns: %s mismatch, got %h, want %h", $realtime, what, got, exp_val);
    error_count++;
  endtask

  task automatic send_req(logic [1:0] kind, logic [7:0] ch);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= ch;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    parse_request(kind, ch);
    items_sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_req(REQ_CHAR, s[i]);
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (parser_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // All-F address with two bytes, so the second write wraps to zero.
  task automatic test_full_line();
    send_text("FFFFFF     a5 00");
    send_req(REQ_EOL, 8'hFF);
    drain_results();
  endtask

  // Unused request kind, a top-code character, a NUL that kills the rest of
  // the line, and a fresh load.
  task automatic test_odd_requests();
    send_req(REQ_UNUSED, 8'hFF);
    send_req(REQ_CHAR, 8'hFF);
    send_req(REQ_CHAR, CHAR_NUL);
    send_req(REQ_CHAR, "1");
    send_req(REQ_LOAD, 8'h00);
    drain_results();
  endtask

  task automatic send_random_line();
    logic [7:0] text[$];
    logic [7:0] hi;
    logic [7:0] lo;
    int pick;
    int len;
    pick = $urandom_range(99);
    if (pick < 70) begin
      for (int i = 0; i < 6; i++) text.push_back(hex_char($urandom_range(15)));
      if ($urandom_range(9) == 0) text[$urandom_range(5)] = rand_non_hex();
      if ($urandom_range(9) == 0) text.push_back(CHAR_R);
      else if ($urandom_range(3) == 0) text.push_back(8'($urandom_range(1, 255)));
      else text.push_back(" ");
      repeat (4) text.push_back(" ");
      repeat (4) begin
        hi = hex_char($urandom_range(15));
        lo = hex_char($urandom_range(15));
        if ($urandom_range(9) == 0) begin
          if ($urandom_range(1) != 0) hi = rand_non_hex();
          else lo = rand_non_hex();
        end
        text.push_back(hi);
        text.push_back(lo);
        text.push_back(" ");
      end
      pick = $urandom_range(9);
      if (pick == 0) begin
        len = $urandom_range(22);
        while (text.size() > len) void'(text.pop_back());
      end else if (pick == 1) begin
        len = $urandom_range(30, 40);
        while (text.size() < len) text.push_back(8'($urandom_range(255)));
      end
      if ($urandom_range(19) == 0 && text.size() > 0) begin
        text[$urandom_range(text.size() - 1)] = CHAR_NUL;
      end
    end else if (pick < 88) begin
      len = $urandom_range(40);
      repeat (len) text.push_back(8'($urandom_range(255)));
    end else begin
      // Short lines of hex digits only, around the minimum line length.
      len = $urandom_range(9);
      repeat (len) text.push_back(hex_char($urandom_range(15)));
    end
    foreach (text[i]) begin
      if ($urandom_range(99) == 0) send_req(REQ_UNUSED, 8'($urandom_range(255)));
      send_req(REQ_CHAR, text[i]);
    end
    pick = $urandom_range(99);
    if (pick < 85) begin
      send_req(REQ_EOL, 8'($urandom_range(255)));
    end else if (pick < 93) begin
      send_req(REQ_LOAD, 8'($urandom_range(255)));
    end else if (pick < 97) begin
      send_req(REQ_UNUSED, 8'($urandom_range(255)));
      send_req(REQ_EOL, 8'($urandom_range(255)));
    end
  endtask

  task automatic test_random_listing(int send_idle, int recv_stall, int quota);
    int start;
    start = items_sent;
    idle_pct = send_idle;
    stall_pct = recv_stall;
    while (items_sent - start < quota) send_random_line();
    drain_results();
  endtask

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (parser_results.size() == 0) begin
        flag_mismatch("unexpected result", m_tdata[23:0], 24'h0);
      end else begin
        want = parser_results.pop_front();
        if (m_tuser[0] !== want.write_valid) begin
          flag_mismatch("write_valid", 24'(m_tuser[0]), 24'(want.write_valid));
        end
        if (m_tdata[23:0] !== want.write_addr) begin
          flag_mismatch("write_addr", m_tdata[23:0], want.write_addr);
        end
        if (m_tdata[31:24] !== want.write_data) begin
          flag_mismatch("write_data", 24'(m_tdata[31:24]), 24'(want.write_data));
        end
        if (m_tdata[32] !== want.first_found) begin
          flag_mismatch("first_found", 24'(m_tdata[32]), 24'(want.first_found));
        end
        if (m_tdata[56:33] !== want.first_addr) begin
          flag_mismatch("first_addr", m_tdata[56:33], want.first_addr);
        end
        if (m_tdata[80:57] !== want.byte_count) begin
          flag_mismatch("byte_count", m_tdata[80:57], want.byte_count);
        end
      end
    end
  end

  // Ends a hung run: counts cycles in which neither side moves a request.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("listing_hex_record_loader_test: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_full_line();
    test_odd_requests();
    test_random_listing(0, 0, 310);
    test_random_listing(78, 0, 310);
    test_random_listing(0, 78, 310);
    test_random_listing(25, 25, 310);
    if (error_count == 0 && parser_results.size() == 0) begin
      $display("listing_hex_record_loader_test: clean");
    end else begin
      $display("listing_hex_record_loader_test: errors");
    end
    $finish;
  end

endmodule
